/* rtl/pickup_delivery_state_expand_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the pickup and delivery state expansion block
// Concurrent checks can be removed from a build by defining ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef PICKUP_DELIVERY_STATE_EXPAND_DEFINES_SVH
`define PICKUP_DELIVERY_STATE_EXPAND_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked on every rising edge outside reset.
`define PDSE_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define PDSE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PDSE_ASSERT(label, clk, rstn, prop, msg)
`define PDSE_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

/* rtl/pdse_pkg.sv */
// ----------------------------------------------------------------------------
// pdse_pkg
// Types and constants shared by the pickup and delivery state expansion block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pdse_pkg;

    localparam int NODE_BITS  = 5;
    localparam int NODES      = 1 << NODE_BITS;
    localparam int ADDR_BITS  = 2 * NODE_BITS;
    localparam int COST_DEPTH = NODES * NODES;
    localparam int COST_BITS  = 32;

    // Largest representable cost, one bit wider so that a carry can be compared.
    localparam logic [COST_BITS:0] COST_LIMIT = {1'b0, {COST_BITS{1'b1}}};

    localparam logic [1:0] CMD_LOAD_COST = 2'd0;
    localparam logic [1:0] CMD_LOAD_PAIR = 2'd1;
    localparam logic [1:0] CMD_INIT      = 2'd2;
    localparam logic [1:0] CMD_EXPAND    = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [4:0]  node_a;
        logic [4:0]  node_b;
        logic [31:0] cost_value;
        logic [31:0] domain_mask;
        logic [4:0]  last_node;
        logic        path_empty;
        logic [4:0]  lower_bound;
        logic [4:0]  upper_bound;
        logic [31:0] incumbent_cost;
    } pdse_in_t;

    typedef struct packed {
        logic [4:0]  node;
        logic [31:0] path_cost;
        logic [31:0] next_domain;
        logic        has_node;
        logic        last;
    } pdse_out_t;

endpackage

/* rtl/pickup_delivery_state_expand.sv */
// ----------------------------------------------------------------------------
// pickup_delivery_state_expand
// Successor expansion for pickup and delivery tour search over a cost memory.
// ----------------------------------------------------------------------------
// Input items arrive on s_valid/s_ready/s_data and results leave on
// m_valid/m_ready/m_data, each moved by a valid-ready transfer.
// Load commands write the cost memory or the pickup table in the cycle of
// their transfer and produce no result; the block is ready again next cycle.
// An init command gives its single result via the pending and output registers.
// An expand command walks every node index through a scan counter, one node
// per cycle while no admissible node is found; an admissible node also passes
// through an evaluation state for the cost memory read, which has a single
// read port. One input item is in work at a time and s_ready is high only
// while the block waits for work.
// Each result is held back one step so that the final one carries last; an
// expand with no survivor yields one result with has_node clear.
// When the receiver stalls, the output register holds its result and the scan
// halts at the next survivor until the transfer completes.
// Reset clears the pickup set, the control state and the output valid; the
// cost and delivery memories keep their contents and are undefined until
// written, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pickup_delivery_state_expand_defines.svh"

module pickup_delivery_state_expand (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  pdse_pkg::pdse_in_t s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output pdse_pkg::pdse_out_t m_data
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_EVAL  = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    localparam logic [pdse_pkg::NODE_BITS-1:0] IDX_LAST =
        pdse_pkg::NODE_BITS'(pdse_pkg::NODES - 1);

    // Memories
    logic [pdse_pkg::COST_BITS-1:0] cost_mem [pdse_pkg::COST_DEPTH];
    logic [pdse_pkg::NODE_BITS-1:0] deliv_mem [pdse_pkg::NODES];

    state_t state_reg, state_next;
    logic [pdse_pkg::NODE_BITS-1:0] idx_reg, idx_next;
    logic                           pend_valid_reg, pend_valid_next;
    pdse_pkg::pdse_out_t            pend_reg, pend_next;
    logic                           pend_load;
    logic                           m_valid_reg, m_valid_next;
    pdse_pkg::pdse_out_t            m_data_reg, m_data_next;
    logic                           out_load;
    logic [pdse_pkg::NODES-1:0]     pickup_reg;

    logic [pdse_pkg::COST_BITS-1:0] cval_reg;
    logic [31:0]                    dom_reg;
    logic [pdse_pkg::NODE_BITS-1:0] from_reg;
    logic [pdse_pkg::NODE_BITS-1:0] lo_reg;
    logic [pdse_pkg::NODE_BITS-1:0] hi_reg;
    logic [31:0]                    inc_reg;

    logic [pdse_pkg::COST_BITS-1:0] cost_rd_reg;
    logic [pdse_pkg::NODE_BITS-1:0] deliv_rd_reg;

    logic                           s_fire;
    logic                           out_free;
    logic                           rd_en;
    logic                           cand;
    logic                           scan_end;
    logic [pdse_pkg::COST_BITS:0]   sum_wide;
    logic [pdse_pkg::COST_BITS-1:0] sum_sat;
    logic                           survivor;
    logic [31:0]                    node_bit;
    logic [31:0]                    deliv_bit;
    logic [31:0]                    new_dom;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign cand     = dom_reg[idx_reg] && (idx_reg >= lo_reg) && (idx_reg <= hi_reg);
    assign scan_end = (idx_reg == IDX_LAST);

    // Saturating add of the state cost and the edge cost.
    assign sum_wide = {1'b0, cval_reg} + {1'b0, cost_rd_reg};
    assign sum_sat  = (sum_wide > pdse_pkg::COST_LIMIT) ?
                      pdse_pkg::COST_LIMIT[pdse_pkg::COST_BITS-1:0] :
                      sum_wide[pdse_pkg::COST_BITS-1:0];
    assign survivor = (32'(sum_sat) < inc_reg);

    assign node_bit  = 32'(1) << idx_reg;
    assign deliv_bit = 32'(1) << deliv_rd_reg;
    assign new_dom   = (dom_reg & ~node_bit) | (pickup_reg[idx_reg] ? deliv_bit : 32'd0);

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        pend_load       = 1'b0;
        out_load        = 1'b0;
        m_data_next     = m_data_reg;
        rd_en           = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (s_data.command)
                        pdse_pkg::CMD_INIT: begin
                            pend_load             = 1'b1;
                            pend_valid_next       = 1'b1;
                            pend_next.node        = '0;
                            pend_next.path_cost   = '0;
                            pend_next.next_domain = 32'(pickup_reg);
                            pend_next.has_node    = 1'b1;
                            pend_next.last        = 1'b0;
                            state_next            = ST_FLUSH;
                        end
                        pdse_pkg::CMD_EXPAND: begin
                            idx_next        = '0;
                            pend_valid_next = 1'b0;
                            state_next      = ST_SCAN;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (cand) begin
                    rd_en      = 1'b1;
                    state_next = ST_EVAL;
                end else if (scan_end) begin
                    state_next = ST_FLUSH;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_EVAL: begin
                // A second survivor must wait until the held one can move on.
                if (!(survivor && pend_valid_reg && !out_free)) begin
                    if (survivor) begin
                        if (pend_valid_reg) begin
                            out_load    = 1'b1;
                            m_data_next = pend_reg;
                        end
                        pend_load             = 1'b1;
                        pend_valid_next       = 1'b1;
                        pend_next.node        = idx_reg;
                        pend_next.path_cost   = 32'(sum_sat);
                        pend_next.next_domain = new_dom;
                        pend_next.has_node    = 1'b1;
                        pend_next.last        = 1'b0;
                    end
                    if (scan_end) begin
                        state_next = ST_FLUSH;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (pend_valid_reg) begin
                        m_data_next      = pend_reg;
                        m_data_next.last = 1'b1;
                    end else begin
                        m_data_next      = '0;
                        m_data_next.last = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            pickup_reg     <= '0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            if (s_fire && (s_data.command == pdse_pkg::CMD_LOAD_PAIR)) begin
                pickup_reg[s_data.node_a] <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (pend_load) begin
            pend_reg <= pend_next;
        end
        if (out_load) begin
            m_data_reg <= m_data_next;
        end
        if (s_fire && (s_data.command == pdse_pkg::CMD_EXPAND)) begin
            cval_reg <= s_data.cost_value[pdse_pkg::COST_BITS-1:0];
            dom_reg  <= s_data.domain_mask;
            from_reg <= s_data.path_empty ? '0 : s_data.last_node;
            lo_reg   <= s_data.lower_bound;
            hi_reg   <= s_data.upper_bound;
            inc_reg  <= s_data.incumbent_cost;
        end
    end

    // Cost memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (s_fire && (s_data.command == pdse_pkg::CMD_LOAD_COST)) begin
            cost_mem[{s_data.node_a, s_data.node_b}] <=
                s_data.cost_value[pdse_pkg::COST_BITS-1:0];
        end
        if (rd_en) begin
            cost_rd_reg <= cost_mem[{from_reg, idx_reg}];
        end
    end

    // Delivery memory, read alongside the cost entry of the same node.
    always_ff @(posedge aclk) begin
        if (s_fire && (s_data.command == pdse_pkg::CMD_LOAD_PAIR)) begin
            deliv_mem[s_data.node_a] <= s_data.node_b;
        end
        if (rd_en) begin
            deliv_rd_reg <= deliv_mem[idx_reg];
        end
    end

    // Assertions
    `PDSE_ASSERT(a_idle_no_pending, aclk, aresetn, (state_reg == ST_IDLE) |-> !pend_valid_reg, "pending result left over in idle")
    `PDSE_ASSERT(a_empty_is_last, aclk, aresetn, (m_valid_reg && !m_data_reg.has_node) |-> m_data_reg.last, "empty result without last")
    `PDSE_ASSERT(a_eval_holds, aclk, aresetn, (state_reg == ST_EVAL && pend_valid_reg && survivor && !out_free) |=> (state_reg == ST_EVAL), "survivor dropped while output stalled")
    `PDSE_ASSERT(a_load_returns_idle, aclk, aresetn, (s_fire && (s_data.command == pdse_pkg::CMD_LOAD_COST || s_data.command == pdse_pkg::CMD_LOAD_PAIR)) |=> (state_reg == ST_IDLE), "load command left idle")
    `PDSE_ASSERT_ALWAYS(a_reset_clears_pickup, aclk, !aresetn |=> (pickup_reg == '0 && !m_valid_reg), "reset did not clear pickup set")

endmodule
